// ----- rtl/ctpg_pkg.sv -----
package ctpg_pkg;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_ADDR_W-1:0] REG_LED_COUNT    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TRAIL_LENGTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HUE_STEP     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SATURATION   = 2'd3;

    // field widths
    localparam int PIX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int HUE_W  = 9;
    localparam int CHAN_W = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // ring and colour constants
    localparam logic [CNT_W-1:0]  RING_MAX       = 9'd256;
    localparam logic [CNT_W-1:0]  LED_COUNT_RST  = 9'd256;
    localparam logic [CNT_W-1:0]  TRAIL_RST      = 9'd40;
    localparam logic [HUE_W-1:0]  HUE_STEP_RST   = 9'd3;
    localparam logic [CHAN_W-1:0] SATURATION_RST = 8'd255;
    localparam logic [HUE_W-1:0]  HUE_WRAP       = 9'd360;
    localparam logic [CHAN_W-1:0] FULL_SCALE     = 8'd255;

    // shift-subtract divider
    localparam int DIV_W     = 16;
    localparam int DIV_CNT_W = 4;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

endpackage

// ----- rtl/comet_trail_pixel_generator.sv -----
// one pixel colour per word; s_axis_tready is high only while idle
// a word goes through head, distance, divide and six multiply steps before its result reaches m_axis_tdata;
// a dark pixel skips divide and multiply; a head past a shrunken ring is first reduced by a divide
// a new word is taken only after the last has reached the output register, later if output is held
// the work is done by the 16-step shift-subtract divider and six passes of the shared 8x8 multiplier
// i_rst_n is synchronous: head, hue, registers and handshakes return to their reset values
module comet_trail_pixel_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ctpg_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [ctpg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ctpg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel_index
    input  logic                             s_axis_tlast,   // frame_done
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ctpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_DIV,
        ST_DIST,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        M_VAL,
        M_SA,
        M_SB,
        M_P,
        M_Q,
        M_T
    } t_mstep;

    typedef enum logic [2:0] {
        SEC_RY,
        SEC_YG,
        SEC_GC,
        SEC_CB,
        SEC_BM,
        SEC_MR
    } t_sector;

    t_state r_state;
    t_mstep r_mstep;

    logic [ctpg_pkg::CNT_W-1:0]  r_led_count;
    logic [ctpg_pkg::CNT_W-1:0]  r_trail_length;
    logic [ctpg_pkg::HUE_W-1:0]  r_hue_step;
    logic [ctpg_pkg::CHAN_W-1:0] r_saturation;

    logic [ctpg_pkg::PIX_W-1:0]  r_head_pos;
    logic [ctpg_pkg::HUE_W-1:0]  r_hue;

    logic [ctpg_pkg::PIX_W-1:0]  r_idx;
    logic                        r_last;
    logic [ctpg_pkg::PIX_W-1:0]  r_head;
    logic                        r_lit;
    logic                        r_div_head;

    logic [ctpg_pkg::DIV_W-1:0]     r_dvd;
    logic [ctpg_pkg::CNT_W-1:0]     r_dvs;
    logic [ctpg_pkg::CHAN_W-1:0]    r_rem;
    logic [ctpg_pkg::DIV_CNT_W-1:0] r_div_cnt;

    logic [ctpg_pkg::CHAN_W-1:0] r_raw, r_v, r_a, r_b, r_p, r_q, r_t;

    logic                          r_out_valid;
    logic [ctpg_pkg::OUT_TDATA_W-1:0] r_out_data;

    // ring size and effective trail
    logic [ctpg_pkg::CNT_W-1:0] ring_n;
    logic [ctpg_pkg::CNT_W-1:0] trail_len;

    always_comb begin
        priority if (r_led_count == '0) begin
            ring_n = ctpg_pkg::CNT_W'(1);
        end else if (r_led_count > ctpg_pkg::RING_MAX) begin
            ring_n = ctpg_pkg::RING_MAX;
        end else begin
            ring_n = r_led_count;
        end
        trail_len = (r_trail_length > ring_n) ? ring_n : r_trail_length;
    end

    // distance behind the head, one wrap at most while head and index are below the ring
    logic [ctpg_pkg::CNT_W:0]   dist_sum;
    logic [ctpg_pkg::CNT_W:0]   dist_wrap;
    logic [ctpg_pkg::CNT_W-1:0] trail_dist;
    logic                       idx_in_ring;
    logic                       pix_lit;
    logic [ctpg_pkg::CNT_W-1:0] span;
    logic [ctpg_pkg::CNT_W+7:0] span_x255;

    assign dist_sum    = {2'b00, r_head} + {1'b0, ring_n} - {2'b00, r_idx};
    assign dist_wrap   = (dist_sum >= {1'b0, ring_n}) ? dist_sum - {1'b0, ring_n} : dist_sum;
    assign trail_dist  = dist_wrap[ctpg_pkg::CNT_W-1:0];
    assign idx_in_ring = ({1'b0, r_idx} < ring_n);
    assign pix_lit     = idx_in_ring && (trail_len != '0) && (trail_dist < trail_len);
    assign span        = trail_len - trail_dist;
    assign span_x255   = {span, 8'h00} - {8'h00, span};

    // divider step
    logic [ctpg_pkg::CHAN_W:0]   div_trial;
    logic                        div_ge;
    logic [ctpg_pkg::CHAN_W-1:0] n_rem;
    logic [ctpg_pkg::CNT_W-1:0]  div_diff;

    assign div_trial = {r_rem, r_dvd[ctpg_pkg::DIV_W-1]};
    assign div_ge    = (div_trial >= r_dvs);
    assign div_diff  = div_trial - r_dvs;
    assign n_rem     = div_ge ? div_diff[ctpg_pkg::CHAN_W-1:0] : div_trial[ctpg_pkg::CHAN_W-1:0];

    // hue sector and scaled remainder, (m*255)/60 is m*17/4
    t_sector                     sector;
    logic [ctpg_pkg::HUE_W-1:0]  sec_base;
    logic [5:0]                  sec_off;
    logic [9:0]                  off_x17;
    logic [ctpg_pkg::CHAN_W-1:0] hue_rem;

    always_comb begin
        priority if (r_hue < 9'd60) begin
            sector = SEC_RY; sec_base = 9'd0;
        end else if (r_hue < 9'd120) begin
            sector = SEC_YG; sec_base = 9'd60;
        end else if (r_hue < 9'd180) begin
            sector = SEC_GC; sec_base = 9'd120;
        end else if (r_hue < 9'd240) begin
            sector = SEC_CB; sec_base = 9'd180;
        end else if (r_hue < 9'd300) begin
            sector = SEC_BM; sec_base = 9'd240;
        end else begin
            sector = SEC_MR; sec_base = 9'd300;
        end
    end

    logic [ctpg_pkg::HUE_W-1:0] hue_off_full;
    assign hue_off_full = r_hue - sec_base;
    assign sec_off      = hue_off_full[5:0];
    assign off_x17      = {sec_off, 4'h0} + {4'h0, sec_off};
    assign hue_rem      = off_x17[9:2];

    // shared multiplier with exact divide by 255 for products of two bytes
    logic [ctpg_pkg::CHAN_W-1:0] mul_a, mul_b;
    logic [15:0]                 mul_p;
    logic [16:0]                 mul_adj;
    logic [ctpg_pkg::CHAN_W-1:0] mul_q;

    always_comb begin
        unique case (r_mstep)
            M_VAL:   begin mul_a = r_raw;        mul_b = r_raw; end
            M_SA:    begin mul_a = r_saturation; mul_b = hue_rem; end
            M_SB:    begin mul_a = r_saturation; mul_b = ctpg_pkg::FULL_SCALE - hue_rem; end
            M_P:     begin mul_a = r_v;          mul_b = ctpg_pkg::FULL_SCALE - r_saturation; end
            M_Q:     begin mul_a = r_v;          mul_b = ctpg_pkg::FULL_SCALE - r_a; end
            M_T:     begin mul_a = r_v;          mul_b = ctpg_pkg::FULL_SCALE - r_b; end
            default: begin mul_a = '0;           mul_b = '0; end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    assign mul_adj = {1'b0, mul_p} + 17'd1 + {9'h000, mul_p[15:8]};
    assign mul_q   = mul_adj[15:8];

    // colour assembly
    logic [ctpg_pkg::CHAN_W-1:0] col_r, col_g, col_b;

    always_comb begin
        unique case (sector)
            SEC_RY:  begin col_r = r_v; col_g = r_t; col_b = r_p; end
            SEC_YG:  begin col_r = r_q; col_g = r_v; col_b = r_p; end
            SEC_GC:  begin col_r = r_p; col_g = r_v; col_b = r_t; end
            SEC_CB:  begin col_r = r_p; col_g = r_q; col_b = r_v; end
            SEC_BM:  begin col_r = r_t; col_g = r_p; col_b = r_v; end
            SEC_MR:  begin col_r = r_v; col_g = r_p; col_b = r_q; end
            default: begin col_r = r_v; col_g = r_p; col_b = r_q; end
        endcase
    end

    // head and hue advance
    logic [ctpg_pkg::CNT_W-1:0] head_inc;
    logic [ctpg_pkg::PIX_W-1:0] n_head_pos;
    logic [ctpg_pkg::HUE_W-1:0] step_mod;
    logic [ctpg_pkg::HUE_W:0]   hue_sum;
    logic [ctpg_pkg::HUE_W:0]   hue_wrap;
    logic [ctpg_pkg::HUE_W-1:0] n_hue;

    assign head_inc   = {1'b0, r_head} + 9'd1;
    assign n_head_pos = (head_inc == ring_n) ? '0 : head_inc[ctpg_pkg::PIX_W-1:0];
    assign step_mod   = (r_hue_step >= ctpg_pkg::HUE_WRAP) ? r_hue_step - ctpg_pkg::HUE_WRAP
                                                           : r_hue_step;
    assign hue_sum    = {1'b0, r_hue} + {1'b0, step_mod};
    assign hue_wrap   = (hue_sum >= {1'b0, ctpg_pkg::HUE_WRAP})
                      ? hue_sum - {1'b0, ctpg_pkg::HUE_WRAP} : hue_sum;
    assign n_hue      = hue_wrap[ctpg_pkg::HUE_W-1:0];

    logic out_load;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_mstep        <= M_VAL;
            r_led_count    <= ctpg_pkg::LED_COUNT_RST;
            r_trail_length <= ctpg_pkg::TRAIL_RST;
            r_hue_step     <= ctpg_pkg::HUE_STEP_RST;
            r_saturation   <= ctpg_pkg::SATURATION_RST;
            r_head_pos     <= '0;
            r_hue          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    ctpg_pkg::REG_LED_COUNT:    r_led_count    <= i_cfg_data;
                    ctpg_pkg::REG_TRAIL_LENGTH: r_trail_length <= i_cfg_data;
                    ctpg_pkg::REG_HUE_STEP:     r_hue_step     <= i_cfg_data;
                    ctpg_pkg::REG_SATURATION:   r_saturation   <= i_cfg_data[ctpg_pkg::CHAN_W-1:0];
                    default: ;
                endcase
            end

            // a new word replaces the one leaving in the same cycle
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_idx   <= s_axis_tdata[ctpg_pkg::PIX_W-1:0];
                        r_last  <= s_axis_tlast;
                        r_state <= ST_HEAD;
                    end
                end
                ST_HEAD: begin
                    if ({1'b0, r_head_pos} < ring_n) begin
                        r_head  <= r_head_pos;
                        r_state <= ST_DIST;
                    end else begin
                        // ring has shrunk below the head: reduce it
                        r_dvd      <= {8'h00, r_head_pos};
                        r_dvs      <= ring_n;
                        r_rem      <= '0;
                        r_div_cnt  <= '0;
                        r_div_head <= 1'b1;
                        r_state    <= ST_DIV;
                    end
                end
                ST_DIST: begin
                    r_lit <= pix_lit;
                    if (pix_lit) begin
                        r_dvd      <= span_x255[ctpg_pkg::DIV_W-1:0];
                        r_dvs      <= trail_len;
                        r_rem      <= '0;
                        r_div_cnt  <= '0;
                        r_div_head <= 1'b0;
                        r_state    <= ST_DIV;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DIV: begin
                    r_rem     <= n_rem;
                    r_dvd     <= {r_dvd[ctpg_pkg::DIV_W-2:0], div_ge};
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == ctpg_pkg::DIV_LAST) begin
                        if (r_div_head) begin
                            r_head  <= n_rem;
                            r_state <= ST_DIST;
                        end else begin
                            r_raw   <= {r_dvd[ctpg_pkg::CHAN_W-2:0], div_ge};
                            r_mstep <= M_VAL;
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    unique case (r_mstep)
                        M_VAL: begin r_v <= mul_q; r_mstep <= M_SA; end
                        M_SA:  begin r_a <= mul_q; r_mstep <= M_SB; end
                        M_SB:  begin r_b <= mul_q; r_mstep <= M_P; end
                        M_P:   begin r_p <= mul_q; r_mstep <= M_Q; end
                        M_Q:   begin r_q <= mul_q; r_mstep <= M_T; end
                        M_T:   begin r_t <= mul_q; r_mstep <= M_VAL; r_state <= ST_DONE; end
                        default: r_mstep <= M_VAL;
                    endcase
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_out_data  <= r_lit ? {col_b, col_g, col_r} : '0;
                        if (r_last) begin
                            r_head_pos <= n_head_pos;
                            r_hue      <= n_hue;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/ctpg_checker.sv -----
module ctpg_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [ctpg_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // one word at a time: busy right after an accept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // no result shows up right behind an accept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // a new result is only handed over at the end of a busy spell
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result without work in flight");

    // reset empties the output and frees the input
    assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset state wrong");

endmodule

bind comet_trail_pixel_generator ctpg_checker u_ctpg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
